### rtl/gemm_tile_outer_product_accumulate_macros.svh
// ----------------------------------------------------------------------------
// GEMM tile engine assertion macros
// Shared concurrent assertion forms for the tile engine.
// ----------------------------------------------------------------------------
`ifndef GEMM_TILE_OUTER_PRODUCT_ACCUMULATE_MACROS_SVH
`define GEMM_TILE_OUTER_PRODUCT_ACCUMULATE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GTOPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define GTOPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gtopa_pkg.sv
// ----------------------------------------------------------------------------
// gtopa_pkg
// Types and constants shared by the GEMM tile engine modules.
// ----------------------------------------------------------------------------
package gtopa_pkg;

  localparam int TILE_ROWS = 16;
  localparam int TILE_COLS = 6;
  localparam int NWORDS    = 8;
  localparam int COL_W     = 3;
  localparam int FMA_LAT   = 4;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;

  // func codes
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_MERGE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROWS_VALID = 1'b0;
  localparam logic CFG_COLS_VALID = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] word_0;
    logic [63:0] word_1;
    logic [63:0] word_2;
    logic [63:0] word_3;
    logic [63:0] word_4;
    logic [63:0] word_5;
    logic [63:0] word_6;
    logic [63:0] word_7;
    logic [63:0] bpair_0;
    logic [63:0] bpair_1;
    logic [63:0] bpair_2;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  column;
    logic        final_res;
    logic [63:0] out_0;
    logic [63:0] out_1;
    logic [63:0] out_2;
    logic [63:0] out_3;
    logic [63:0] out_4;
    logic [63:0] out_5;
    logic [63:0] out_6;
    logic [63:0] out_7;
  } out_item_t;

  // one column operation travelling through the lanes
  typedef struct packed {
    logic             vld;
    logic             merge;
    logic             last;
    logic [COL_W-1:0] col;
  } op_t;

endpackage

### rtl/gemm_tile_outer_product_accumulate.sv
// ----------------------------------------------------------------------------
// gemm_tile_outer_product_accumulate
// 16x6 binary32 GEMM tile engine: outer-product accumulate and C merge.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one transaction: func = step adds the
//   outer product of 16 A values and 6 B values into the accumulators,
//   func = merge returns one C column plus the accumulators.
//   out_valid/out_ready/out_data return one transaction per merge only.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write rows_valid (index 0) and
//   cols_valid (index 1); write only while the engine is idle.
// Timing:
//   Sixteen FMA lanes process one tile column per cycle; the FMA is four
//   stages deep. A step issues its six columns in turn, then drains the
//   lanes before in_ready returns. A merge issues its column once the
//   output register is free, and its result is captured in the output
//   register as it retires; in_ready returns after the drain.
// Reset (rst_n low, synchronous): accumulators read +0.0, merge column 0,
//   rows_valid 16, cols_valid 6, no result pending.
// Backpressure: a held result does not block step transactions; a merge
//   waits at issue until the output register has been taken.
// ----------------------------------------------------------------------------
module gemm_tile_outer_product_accumulate
  import gtopa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

`include "gemm_tile_outer_product_accumulate_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  in_item_t                   item_r;
  logic [COL_W-1:0]           col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0]           merge_col_r, merge_col_nxt;
  logic [4:0]                 rows_valid_r;
  logic [2:0]                 cols_valid_r;
  op_t                        iss;
  op_t                        ret_r [FMA_LAT];
  logic [2:0]                 ncols;
  logic                       merge_last, in_flight;
  logic [NWORDS-1:0][63:0]    words;
  logic [TILE_ROWS-1:0][31:0] a_lane, res;
  logic [TILE_COLS-1:0][31:0] b_col;
  logic [31:0]                b_op;

  // ---- configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_valid_r <= 5'd16;
      cols_valid_r <= 3'd6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_VALID: rows_valid_r <= cfg_data[4:0];
        CFG_COLS_VALID: cols_valid_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---- input register
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // ---- operand lanes
  always_comb begin
    words = {item_r.word_7, item_r.word_6, item_r.word_5, item_r.word_4,
             item_r.word_3, item_r.word_2, item_r.word_1, item_r.word_0};
    for (int r = 0; r < TILE_ROWS; r++) begin
      a_lane[r] = r[0] ? words[r/2][63:32] : words[r/2][31:0];
    end
    b_col = {item_r.bpair_2, item_r.bpair_1, item_r.bpair_0};
    b_op  = (item_r.func == FUNC_MERGE) ? FP_ONE : b_col[col_cnt_r];
  end

  // ---- effective column count and last-column test
  always_comb begin
    if (cols_valid_r == 3'd0) begin
      ncols = 3'd1;
    end else if (cols_valid_r > 3'(TILE_COLS)) begin
      ncols = 3'(TILE_COLS);
    end else begin
      ncols = cols_valid_r;
    end
    merge_last = ({1'b0, merge_col_r} + 4'd1) >= {1'b0, ncols};
  end

  // ---- issue control
  always_comb begin
    in_flight = 1'b0;
    for (int i = 0; i < FMA_LAT - 1; i++) begin
      in_flight = in_flight | ret_r[i].vld;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    col_cnt_nxt   = col_cnt_r;
    merge_col_nxt = merge_col_r;
    iss           = '0;
    unique case (state_r)
      ST_IDLE: begin
        col_cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (item_r.func == FUNC_STEP) begin
          iss.vld     = 1'b1;
          iss.col     = col_cnt_r;
          col_cnt_nxt = col_cnt_r + 1'b1;
          if (col_cnt_r == COL_W'(TILE_COLS - 1)) begin
            state_nxt = ST_DRAIN;
          end
        end else if (!out_valid) begin
          iss.vld       = 1'b1;
          iss.merge     = 1'b1;
          iss.last      = merge_last;
          iss.col       = merge_col_r;
          merge_col_nxt = merge_last ? '0 : merge_col_r + 1'b1;
          state_nxt     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!in_flight) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      merge_col_r <= '0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      merge_col_r <= merge_col_nxt;
    end
  end

  // ---- retire pipe, aligned with the FMA stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FMA_LAT; i++) begin
        ret_r[i] <= '0;
      end
    end else begin
      ret_r[0] <= iss;
      for (int i = 1; i < FMA_LAT; i++) begin
        ret_r[i] <= ret_r[i-1];
      end
    end
  end

  // ---- row lanes
  for (genvar g = 0; g < TILE_ROWS; g++) begin : g_lane
    gtopa_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .a     (a_lane[g]),
      .b     (b_op),
      .iss   (iss),
      .ret   (ret_r[FMA_LAT-1]),
      .res   (res[g])
    );
  end

  // ---- result assembly
  gtopa_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ret        (ret_r[FMA_LAT-1]),
    .res        (res),
    .c_lane     (a_lane),
    .rows_valid (rows_valid_r),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // ---- assertions
  `GTOPA_ASSERT_IMP(a_merge_out_free, ret_r[FMA_LAT-1].vld && ret_r[FMA_LAT-1].merge, !out_valid, "merge retired into a full output register")
  `GTOPA_ASSERT_IMP(a_merge_col_range, 1'b1, merge_col_r < COL_W'(TILE_COLS), "merge column out of range")
  `GTOPA_ASSERT_NXT(a_accept_issues, in_valid && in_ready, state_r == ST_ISSUE, "accepted transaction did not start issue")
  `GTOPA_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !ret_r[0].vld && !iss.vld, "lane activity while idle")

endmodule

### rtl/gtopa_fma.sv
// ----------------------------------------------------------------------------
// gtopa_fma
// Four-stage binary32 fused multiply-add, round to nearest even, subnormals
// kept, NaN results canonical. Stages: multiply, align/add, leading-one
// search, shift/round/pack.
// ----------------------------------------------------------------------------
module gtopa_fma
  import gtopa_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] res
);

  // stage 1 registers
  logic [47:0]        s1_mp_r;
  logic [23:0]        s1_mc_r;
  logic signed [11:0] s1_l1_r, s1_l2_r;
  logic               s1_ps_r, s1_sc_r, s1_spec_r;
  logic [31:0]        s1_sval_r;
  // stage 2 registers
  logic [104:0]       s2_mag_r;
  logic               s2_sign_r, s2_spec_r;
  logic signed [11:0] s2_ls_r;
  logic [31:0]        s2_sval_r;
  // stage 3 registers
  logic [104:0]       s3_mag_r;
  logic               s3_sign_r, s3_spec_r;
  logic signed [11:0] s3_t_r, s3_k_r;
  logic [31:0]        s3_sval_r;
  // result register
  logic [31:0]        res_r;

  // ---- stage 1: unpack, multiply, special values
  logic [7:0]         ea, eb, ec, eae, ebe, ece;
  logic [23:0]        ma, mb, mc;
  logic               nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b;
  logic               ps, prod_inf, invalid;
  logic [31:0]        sval;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ec = c[30:23];
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    ece = (ec == 8'd0) ? 8'd1 : ec;
    ma = {ea != 8'd0, a[22:0]};
    mb = {eb != 8'd0, b[22:0]};
    mc = {ec != 8'd0, c[22:0]};
    nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
    nan_c = (ec == 8'hFF) && (c[22:0] != 23'd0);
    inf_a = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (eb == 8'hFF) && (b[22:0] == 23'd0);
    inf_c = (ec == 8'hFF) && (c[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    ps = a[31] ^ b[31];
    prod_inf = inf_a | inf_b;
    invalid = nan_a | nan_b | nan_c | (prod_inf & (zero_a | zero_b)) |
              (prod_inf & inf_c & (ps != c[31]));
    if (invalid) begin
      sval = FP_QNAN;
    end else if (prod_inf) begin
      sval = {ps, 8'hFF, 23'd0};
    end else begin
      sval = {c[31], 8'hFF, 23'd0};
    end
  end

  always_ff @(posedge clk) begin
    s1_mp_r   <= ma * mb;
    s1_mc_r   <= mc;
    s1_l1_r   <= $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd300;
    s1_l2_r   <= $signed({4'd0, ece}) - 12'sd174;
    s1_ps_r   <= ps;
    s1_sc_r   <= c[31];
    s1_spec_r <= invalid | prod_inf | inf_c | nan_c;
    s1_sval_r <= sval;
  end

  // ---- stage 2: align smaller operand into a 104-bit window and add
  logic               pz, cz, sel_p, sb, ss, eff_sub, sticky;
  logic [47:0]        big_m, sm_m, m2;
  logic signed [11:0] lb, lsm;
  logic signed [12:0] d;
  logic [6:0]         dcap;
  logic [103:0]       sm_w, sm_al;
  logic [104:0]       sum, mag;
  logic               sign2;

  always_comb begin
    pz = (s1_mp_r == 48'd0);
    cz = (s1_mc_r == 24'd0);
    m2 = {s1_mc_r, 24'd0};
    sel_p = cz | (!pz && (s1_l1_r >= s1_l2_r));
    big_m = sel_p ? s1_mp_r : m2;
    sm_m  = sel_p ? m2 : s1_mp_r;
    lb    = sel_p ? s1_l1_r : s1_l2_r;
    lsm   = sel_p ? s1_l2_r : s1_l1_r;
    sb    = sel_p ? s1_ps_r : s1_sc_r;
    ss    = sel_p ? s1_sc_r : s1_ps_r;
    d = $signed({lb[11], lb}) - $signed({lsm[11], lsm});
    if ((d < 13'sd0) || (d > 13'sd104)) begin
      dcap = 7'd104;
    end else begin
      dcap = d[6:0];
    end
    sm_w   = {sm_m, 56'd0};
    sm_al  = sm_w >> dcap;
    sticky = ((sm_al << dcap) != sm_w);
    sm_al  = sm_al | {103'd0, sticky};
    eff_sub = sb ^ ss;
    if (eff_sub) begin
      sum = {1'b0, big_m, 56'd0} - {1'b0, sm_al};
    end else begin
      sum = {1'b0, big_m, 56'd0} + {1'b0, sm_al};
    end
    if (eff_sub && sum[104]) begin
      mag   = -sum;
      sign2 = ss;
    end else begin
      mag   = sum;
      sign2 = sb;
    end
    // exact zero: same-sign zeros keep the sign, cancellation gives +0
    if (mag == 105'd0) begin
      sign2 = eff_sub ? 1'b0 : sb;
    end
  end

  always_ff @(posedge clk) begin
    s2_mag_r  <= mag;
    s2_sign_r <= sign2;
    s2_ls_r   <= lb - 12'sd56;
    s2_spec_r <= s1_spec_r;
    s2_sval_r <= s1_sval_r;
  end

  // ---- stage 3: leading-one position, target LSB exponent, shift count
  logic [6:0]         p;
  logic signed [11:0] e3, t3;

  always_comb begin
    p = 7'd0;
    for (int i = 0; i < 105; i++) begin
      if (s2_mag_r[i]) begin
        p = 7'(i);
      end
    end
    e3 = s2_ls_r + $signed({5'd0, p});
    t3 = ((e3 - 12'sd23) > -12'sd149) ? (e3 - 12'sd23) : -12'sd149;
  end

  always_ff @(posedge clk) begin
    s3_mag_r  <= s2_mag_r;
    s3_sign_r <= s2_sign_r;
    s3_t_r    <= t3;
    s3_k_r    <= t3 - s2_ls_r;
    s3_spec_r <= s2_spec_r;
    s3_sval_r <= s2_sval_r;
  end

  // ---- stage 4: shift to 24 bits, round to nearest even, pack
  logic signed [11:0] nk, km1, tn, bexp;
  logic [6:0]         kc;
  logic [104:0]       t4, lsh;
  logic [23:0]        m4, mant;
  logic               g4, st4, inc;
  logic [24:0]        mr;
  logic [31:0]        res_nxt;

  always_comb begin
    nk  = -s3_k_r;
    km1 = s3_k_r - 12'sd1;
    kc  = (km1 > 12'sd105) ? 7'd105 : km1[6:0];
    lsh = s3_mag_r << nk[4:0];
    t4  = s3_mag_r >> kc;
    if (s3_k_r <= 12'sd0) begin
      m4  = lsh[23:0];
      g4  = 1'b0;
      st4 = 1'b0;
    end else begin
      m4  = t4[24:1];
      g4  = t4[0];
      st4 = ((t4 << kc) != s3_mag_r);
    end
    inc = g4 & (st4 | m4[0]);
    mr  = {1'b0, m4} + {24'd0, inc};
    if (mr[24]) begin
      mant = mr[24:1];
      tn   = s3_t_r + 12'sd1;
    end else begin
      mant = mr[23:0];
      tn   = s3_t_r;
    end
    bexp = mant[23] ? (tn + 12'sd150) : 12'sd0;
    if (s3_spec_r) begin
      res_nxt = s3_sval_r;
    end else if (bexp >= 12'sd255) begin
      res_nxt = {s3_sign_r, 8'hFF, 23'd0};
    end else begin
      res_nxt = {s3_sign_r, bexp[7:0], mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

### rtl/gtopa_lane.sv
// ----------------------------------------------------------------------------
// gtopa_lane
// One tile row: the row's column accumulators and its FMA unit.
// Unwritten (cleared) accumulators read as +0.0.
// ----------------------------------------------------------------------------
module gtopa_lane
  import gtopa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  op_t         iss,
  input  op_t         ret,
  output logic [31:0] res
);

  logic [TILE_COLS-1:0][31:0] acc_r;
  logic [TILE_COLS-1:0]       acc_vld_r;
  logic [31:0]                c_op;

  // accumulator read for the column being issued
  assign c_op = acc_vld_r[iss.col] ? acc_r[iss.col] : 32'd0;

  gtopa_fma u_fma (
    .clk (clk),
    .a   (a),
    .b   (b),
    .c   (c_op),
    .res (res)
  );

  // valid bits: set on step writeback, cleared by the last merge of a tile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else begin
      if (ret.vld && !ret.merge) begin
        acc_vld_r[ret.col] <= 1'b1;
      end
      if (iss.vld && iss.merge && iss.last) begin
        acc_vld_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ret.vld && !ret.merge) begin
      acc_r[ret.col] <= res;
    end
  end

endmodule

### rtl/gtopa_merge.sv
// ----------------------------------------------------------------------------
// gtopa_merge
// Collects the lane sums of a merge, applies the row mask and holds the
// result transaction in the output register.
// ----------------------------------------------------------------------------
module gtopa_merge
  import gtopa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  op_t                        ret,
  input  logic [TILE_ROWS-1:0][31:0] res,
  input  logic [TILE_ROWS-1:0][31:0] c_lane,
  input  logic [4:0]                 rows_valid,
  input  logic                       out_ready,
  output logic                       out_valid,
  output out_item_t                  out_data
);

  logic                       out_valid_r;
  out_item_t                  out_data_r;
  logic [TILE_ROWS-1:0][31:0] sel;
  logic [NWORDS-1:0][63:0]    words;
  logic                       cap;

  assign cap = ret.vld && ret.merge;

  // rows past rows_valid return the input C bits untouched
  always_comb begin
    for (int r = 0; r < TILE_ROWS; r++) begin
      sel[r] = (5'(r) < rows_valid) ? res[r] : c_lane[r];
    end
    for (int w = 0; w < NWORDS; w++) begin
      words[w] = {sel[2*w+1], sel[2*w]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cap) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      out_data_r.column    <= ret.col;
      out_data_r.final_res <= ret.last;
      out_data_r.out_0     <= words[0];
      out_data_r.out_1     <= words[1];
      out_data_r.out_2     <= words[2];
      out_data_r.out_3     <= words[3];
      out_data_r.out_4     <= words[4];
      out_data_r.out_5     <= words[5];
      out_data_r.out_6     <= words[6];
      out_data_r.out_7     <= words[7];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/gemm_tile_outer_product_accumulate_test.sv
// ----------------------------------------------------------------------------
// GEMM tile engine testbench
// Drives k-slice and merge transactions into the 16x6 tile engine and checks
// every returned C column against a bit-exact binary32 model of the engine.
// The model uses exact wide-integer arithmetic for the fused multiply-add.
// Directed tests cover the special values, the row mask and the column count.
// A long random run then sends whole tiles and single transactions under several idle/stall mixes.
// ----------------------------------------------------------------------------
module gemm_tile_outer_product_accumulate_test;
  import gtopa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;

  gemm_tile_outer_product_accumulate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Engine model state
  logic [31:0] acc_m [TILE_ROWS][TILE_COLS];
  logic [2:0]  merge_col_m;
  logic [4:0]  rows_valid_m;
  logic [2:0]  cols_valid_m;
  out_item_t   column_results_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int mismatch_count;
  int steps_sent;
  int merges_sent;
  int columns_checked;
  int cfg_writes;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // binary32 helpers
  // ---------------------------------------------------------------------------
  function automatic bit f_is_nan(logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic bit f_is_inf(logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic bit f_is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // a*b + c with a single round to nearest even, subnormals kept
  function automatic logic [31:0] fp_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic         sp, sc, sr;
    logic [23:0]  ma, mb, mc;
    logic [47:0]  mp;
    int           ea, eb, ec, ep, e0, n, sh, q, be;
    logic [511:0] one, big_p, big_c, mag, rem, half, mant;
    one = 512'd1;
    if (f_is_nan(a) || f_is_nan(b) || f_is_nan(c)) return FP_QNAN;
    sp = a[31] ^ b[31];
    sc = c[31];
    // infinities
    if ((f_is_inf(a) && f_is_zero(b)) || (f_is_inf(b) && f_is_zero(a))) return FP_QNAN;
    if (f_is_inf(a) || f_is_inf(b)) begin
      if (f_is_inf(c) && sc != sp) return FP_QNAN;
      return {sp, 8'hFF, 23'd0};
    end
    if (f_is_inf(c)) return c;
    // unpack to integer mantissa times power of two
    ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    mc = (c[30:23] == 8'd0) ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
    ea = ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
    eb = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
    ec = ((c[30:23] == 8'd0) ? 1 : int'(c[30:23])) - 150;
    mp = ma * mb;
    ep = ea + eb;
    if (mp == 48'd0 && mc == 24'd0) return {(sp == sc) ? sc : 1'b0, 31'd0};
    if (mp == 48'd0) return c;
    e0 = (mc != 24'd0 && ec < ep) ? ec : ep;
    big_p = 512'(mp) << (ep - e0);
    big_c = (mc == 24'd0) ? 512'd0 : (512'(mc) << (ec - e0));
    // exact signed sum
    if (sp == sc) begin
      mag = big_p + big_c;
      sr  = sp;
    end else if (big_p >= big_c) begin
      mag = big_p - big_c;
      sr  = sp;
    end else begin
      mag = big_c - big_p;
      sr  = sc;
    end
    if (mag == 512'd0) return 32'd0;
    n = 0;
    for (int i = 511; i >= 0; i--) begin
      if (mag[i]) begin
        n = i;
        break;
      end
    end
    // keep 24 bits, but never finer than the smallest subnormal
    sh = n - 23;
    if (e0 + sh < -149) sh = -149 - e0;
    if (sh <= 0) begin
      mant = mag << (-sh);
    end else begin
      mant = mag >> sh;
      rem  = mag & ((one << sh) - one);
      half = one << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + one;
    end
    q = e0 + sh;
    if (mant[24]) begin
      mant = mant >> 1;
      q = q + 1;
    end
    if (mant == 512'd0) return {sr, 31'd0};
    if (mant[23]) begin
      be = q + 150;
      if (be >= 255) return {sr, 8'hFF, 23'd0};
      return {sr, be[7:0], mant[22:0]};
    end
    return {sr, 8'd0, mant[22:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Engine model
  // ---------------------------------------------------------------------------
  function automatic void model_reset();
    foreach (acc_m[r, c]) acc_m[r][c] = 32'd0;
    merge_col_m  = 3'd0;
    rows_valid_m = 5'd16;
    cols_valid_m = 3'd6;
  endfunction

  // Applies one accepted transaction; a merge queues the expected column
  function automatic void model_apply(in_item_t it);
    logic [63:0] w [8];
    logic [63:0] bp [3];
    logic [31:0] lane_v, b_v, res [16];
    int          ncols;
    bit          last;
    out_item_t   exp_col;
    w  = '{it.word_0, it.word_1, it.word_2, it.word_3,
           it.word_4, it.word_5, it.word_6, it.word_7};
    bp = '{it.bpair_0, it.bpair_1, it.bpair_2};
    if (it.func == FUNC_STEP) begin
      steps_sent++;
      for (int r = 0; r < TILE_ROWS; r++) begin
        lane_v = r[0] ? w[r/2][63:32] : w[r/2][31:0];
        for (int c = 0; c < TILE_COLS; c++) begin
          b_v = c[0] ? bp[c/2][63:32] : bp[c/2][31:0];
          acc_m[r][c] = fp_fma(lane_v, b_v, acc_m[r][c]);
        end
      end
      return;
    end
    merges_sent++;
    ncols = (cols_valid_m == 3'd0) ? 1 : int'(cols_valid_m);
    if (ncols > TILE_COLS) ncols = TILE_COLS;
    last = (int'(merge_col_m) + 1) >= ncols;
    for (int r = 0; r < 16; r++) begin
      lane_v = r[0] ? w[r/2][63:32] : w[r/2][31:0];
      if (r < int'(rows_valid_m) && merge_col_m < TILE_COLS)
        res[r] = fp_fma(lane_v, FP_ONE, acc_m[r][merge_col_m]);
      else
        res[r] = lane_v;
    end
    exp_col.column    = merge_col_m;
    exp_col.final_res = last;
    exp_col.out_0 = {res[1], res[0]};
    exp_col.out_1 = {res[3], res[2]};
    exp_col.out_2 = {res[5], res[4]};
    exp_col.out_3 = {res[7], res[6]};
    exp_col.out_4 = {res[9], res[8]};
    exp_col.out_5 = {res[11], res[10]};
    exp_col.out_6 = {res[13], res[12]};
    exp_col.out_7 = {res[15], res[14]};
    column_results_q.push_back(exp_col);
    if (last) begin
      foreach (acc_m[r, c]) acc_m[r][c] = 32'd0;
      merge_col_m = 3'd0;
    end else begin
      merge_col_m = merge_col_m + 3'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus values
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_f32();
    logic [31:0] specials [10];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                 32'h0080_0000, FP_ONE};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return specials[$urandom_range(0, 9)];
      3:       return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(112, 142)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_f32(), rand_f32()};
  endfunction

  function automatic in_item_t make_item(logic fn);
    in_item_t it;
    it.func    = fn;
    it.word_0  = rand_pair();
    it.word_1  = rand_pair();
    it.word_2  = rand_pair();
    it.word_3  = rand_pair();
    it.word_4  = rand_pair();
    it.word_5  = rand_pair();
    it.word_6  = rand_pair();
    it.word_7  = rand_pair();
    // B is ignored on a merge: send raw bits there
    it.bpair_0 = (fn == FUNC_MERGE) ? {$urandom, $urandom} : rand_pair();
    it.bpair_1 = (fn == FUNC_MERGE) ? {$urandom, $urandom} : rand_pair();
    it.bpair_2 = (fn == FUNC_MERGE) ? {$urandom, $urandom} : rand_pair();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // One input transaction; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      repeat ($urandom_range(1, 6)) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    model_apply(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_tile(int ksteps, int nmerges);
    repeat (ksteps) send_item(make_item(FUNC_STEP));
    repeat (nmerges) send_item(make_item(FUNC_MERGE));
  endtask

  // Waits until every expected column has come back and the lanes drained
  task automatic wait_quiet();
    while (column_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] value);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS_VALID) rows_valid_m = value[4:0];
    else                       cols_valid_m = value[2:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // Receiver back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_col;
    logic [63:0] got_w [8];
    logic [63:0] exp_w [8];
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      if (column_results_q.size() == 0) begin
        fail_count++;
        if (mismatch_count++ < 10)
          $display("ERROR: unexpected column transaction %p", out_data);
      end else begin
        exp_col = column_results_q.pop_front();
        columns_checked++;
        got_w = '{out_data.out_0, out_data.out_1, out_data.out_2, out_data.out_3,
                  out_data.out_4, out_data.out_5, out_data.out_6, out_data.out_7};
        exp_w = '{exp_col.out_0, exp_col.out_1, exp_col.out_2, exp_col.out_3,
                  exp_col.out_4, exp_col.out_5, exp_col.out_6, exp_col.out_7};
        bad = (out_data.column !== exp_col.column) ||
              (out_data.final_res !== exp_col.final_res);
        for (int i = 0; i < 8; i++) if (got_w[i] !== exp_w[i]) bad = 1'b1;
        if (bad) begin
          fail_count++;
          if (mismatch_count++ < 10) begin
            $display("ERROR: column %0d: column exp %0d got %0d, final exp %0b got %0b",
                     columns_checked, exp_col.column, out_data.column,
                     exp_col.final_res, out_data.final_res);
            for (int i = 0; i < 8; i++)
              if (got_w[i] !== exp_w[i])
                $display("  out_%0d exp %h got %h", i, exp_w[i], got_w[i]);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired with %0d columns outstanding",
               column_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset defaults: full tile, all rows, six columns
  task automatic test_reset_defaults();
    send_tile(2, TILE_COLS);
  endtask

  // NaN, infinities, signed zeros, subnormals and overflow in the FMA lanes
  task automatic test_special_values();
    in_item_t it;
    it = make_item(FUNC_STEP);
    it.word_0  = {32'h7FA0_0000, 32'h7F80_0000};   // signaling NaN, +inf
    it.word_1  = {32'h8000_0000, 32'hFF80_0000};   // -0, -inf
    it.word_2  = {32'h0000_0001, 32'h7F7F_FFFF};   // min subnormal, max normal
    it.word_3  = {32'hFF7F_FFFF, 32'h0000_0000};
    it.bpair_0 = {32'h7F80_0000, 32'h0000_0000};   // inf, +0
    it.bpair_1 = {32'hBF80_0000, FP_ONE};
    it.bpair_2 = {32'h0080_0000, 32'h7F7F_FFFF};
    send_item(it);
    send_item(it);
    it = make_item(FUNC_MERGE);
    it.word_0 = {32'hFF80_0000, 32'h7FFF_FFFF};
    it.word_1 = {32'h8000_0000, 32'h0000_0000};
    send_item(it);
    send_tile(0, TILE_COLS - 1);
  endtask

  // Row mask: none, a few, and a value beyond the tile (all rows)
  task automatic test_row_mask();
    write_cfg(CFG_COLS_VALID, 8'd1);
    write_cfg(CFG_ROWS_VALID, 8'd0);
    send_tile(1, 1);
    write_cfg(CFG_ROWS_VALID, 8'd5);
    send_tile(1, 1);
    write_cfg(CFG_ROWS_VALID, 8'd31);
    send_tile(1, 1);
  endtask

  // Column count: zero acts as one, seven as six, shrink during a merge
  task automatic test_column_count();
    write_cfg(CFG_ROWS_VALID, 8'd16);
    write_cfg(CFG_COLS_VALID, 8'd0);
    send_tile(1, 1);
    write_cfg(CFG_COLS_VALID, 8'd7);
    send_tile(1, 3);
    write_cfg(CFG_COLS_VALID, 8'd2);
    send_item(make_item(FUNC_STEP));   // step between merges keeps the column
    send_item(make_item(FUNC_MERGE));
  endtask

  // Random tiles with random configuration under all idling mixes
  task automatic test_random_tiles(int target_items);
    int mode;
    int sent;
    mode = 0;
    sent = 0;
    while (sent < target_items) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_quiet();
        set_idling(mode++);
        if ($urandom_range(0, 1)) write_cfg(CFG_ROWS_VALID, 8'($urandom_range(0, 255)));
        else                      write_cfg(CFG_COLS_VALID, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) == 0) begin
        // hold off until the engine has returned everything
        wait_quiet();
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(1'($urandom)));
        sent++;
      end else begin
        int k, m;
        k = $urandom_range(1, 4);
        m = $urandom_range(1, TILE_COLS);
        send_tile(k, m);
        sent += k + m;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_ROWS_VALID;
    cfg_data        = 8'd0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    fail_count      = 0;
    mismatch_count  = 0;
    steps_sent      = 0;
    merges_sent     = 0;
    columns_checked = 0;
    cfg_writes      = 0;
    quiet_cycles    = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_special_values();
    test_row_mask();
    test_column_count();
    test_random_tiles(1300);

    wait_quiet();
    $display("Covered %0d k-slices, %0d merges, %0d columns checked, %0d config writes",
             steps_sent, merges_sent, columns_checked, cfg_writes);
    $display("Special values, row masks 0..31, column counts 0..7, four idle mixes");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/gtopa_pkg.sv
rtl/gtopa_fma.sv
rtl/gtopa_lane.sv
rtl/gtopa_merge.sv
rtl/gemm_tile_outer_product_accumulate.sv
tb/sv/gemm_tile_outer_product_accumulate_test.sv
